[hw/rtl/aad_pkg.sv]
package aad_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_PLANES = 4;

    localparam int DIM_W    = 12;
    localparam int PCNT_W   = 3;
    localparam int RECIP_W  = 33;
    localparam int CFG_IDX_W = 3;
    localparam int SAMPLE_W = 8;
    localparam int COLACC_W = 19;
    localparam int PIXACC_W = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_RECIP  = 3'd5;

    localparam logic [RECIP_W-1:0] RECIP_RESET = 33'h1_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_READ,
        ST_WRITE,
        ST_HMUL,
        ST_HADD,
        ST_NORM,
        ST_EMIT,
        ST_ADV,
        ST_CLEAR
    } state_t;

endpackage

[hw/rtl/aad_line_store.sv]
module aad_line_store import aad_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_PLANES
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [COLACC_W-1:0]      wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [COLACC_W-1:0]      rd_data
);

    logic [COLACC_W-1:0] mem [DEPTH];
    logic [COLACC_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/area_average_image_downscaler.sv]
// channel  | ports                                   | direction
// s_       | s_valid s_ready s_sample s_frame_start  | source samples in
// m_       | m_valid m_ready m_out_sample m_row_end  | scaled samples out
//          | m_frame_end                             |
// cfg_     | cfg_we cfg_index cfg_wdata              | register writes
// a request passes the idle, init, read, write and adv states; one that closes
// an output row adds hmul and hadd, one that yields a sample norm and emit as
// well; line store read and write-back and the horizontal multipliers set them
// a frame start and a frame end add a clearing pass over the line store entries
// up to the highest one written; after reset the pass covers the whole store
// a held result stalls only a request that yields the next one
module area_average_image_downscaler import aad_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_PLANES = DEF_MAX_PLANES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_sample,
    input  logic                 s_frame_start,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SAMPLE_W-1:0]  m_out_sample,
    output logic                 m_row_end,
    output logic                 m_frame_end,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RECIP_W-1:0]   cfg_wdata
);

    localparam int DEPTH   = MAX_WIDTH * MAX_PLANES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int PLANE_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]   in_width_reg, in_height_reg, out_width_reg, out_height_reg;
    logic [PCNT_W-1:0]  plane_count_reg;
    logic [RECIP_W-1:0] norm_recip_reg;

    logic [DIM_W-1:0]    row_weight_reg, row_weight_next;
    logic [DIM_W-1:0]    row_span_reg, row_span_next;
    logic [DIM_W-1:0]    col_span_reg [MAX_PLANES];
    logic [DIM_W-1:0]    col_span_next [MAX_PLANES];
    logic [PIXACC_W-1:0] pix_acc_reg [MAX_PLANES];
    logic [PIXACC_W-1:0] pix_acc_next [MAX_PLANES];
    logic [COL_W-1:0]    src_col_reg, src_col_next;
    logic [ROW_W-1:0]    src_row_reg, src_row_next;
    logic [PLANE_W-1:0]  plane_reg, plane_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;

    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   hwm_reg, hwm_next;
    logic                clr_read_reg, clr_read_next;

    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                fs_reg, fs_next;
    logic                closes_reg, closes_next;
    logic [19:0]         wprod_reg, wprod_next;
    logic [19:0]         rprod_reg, rprod_next;
    logic [COLACC_W-1:0] v_reg, v_next;
    logic [30:0]         hprod_reg, hprod_next;
    logic [30:0]         hrprod_reg, hrprod_next;
    logic [PIXACC_W-1:0] acc_reg, acc_next;
    logic [61:0]         nprod_reg, nprod_next;

    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_sample_reg, m_sample_next;
    logic                m_row_end_reg, m_row_end_next;
    logic                m_frame_end_reg, m_frame_end_next;

    logic [DIM_W-1:0]    iw, ih, ow, oh, rem, span, h1, hrem;
    logic [PCNT_W-1:0]   np;
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                mem_we, mem_re;
    logic [COLACC_W-1:0] mem_wdata, mem_rdata;

    always_comb begin
        iw = (in_width_reg == '0) ? DIM_W'(1) :
             ((32'(in_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : in_width_reg);
        ih = (in_height_reg == '0) ? DIM_W'(1) :
             ((32'(in_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : in_height_reg);
        ow = (out_width_reg == '0) ? DIM_W'(1) :
             ((out_width_reg > iw) ? iw : out_width_reg);
        oh = (out_height_reg == '0) ? DIM_W'(1) :
             ((out_height_reg > ih) ? ih : out_height_reg);
        np = (plane_count_reg == '0) ? PCNT_W'(1) :
             ((32'(plane_count_reg) > MAX_PLANES) ? PCNT_W'(MAX_PLANES) : plane_count_reg);
        rem  = (oh > row_weight_reg) ? oh - row_weight_reg : '0;
        span = col_span_reg[plane_reg];
        h1   = (span < ow) ? span : ow;
        hrem = ow - h1;
        addr = ADDR_W'(32'(src_col_reg) * MAX_PLANES + 32'(plane_reg));
    end

    aad_line_store #(
        .DEPTH(DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (wr_addr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (addr),
        .rd_data (mem_rdata)
    );

    always_comb begin
        logic                 do_init;
        logic                 line_done;
        logic [30:0]          q;
        logic                 last_plane;
        logic                 re;
        logic [COLACC_W-1:0]  v_sum;
        logic [DIM_W-1:0]     new_span;

        state_next       = state_reg;
        row_weight_next  = row_weight_reg;
        row_span_next    = row_span_reg;
        col_span_next    = col_span_reg;
        pix_acc_next     = pix_acc_reg;
        src_col_next     = src_col_reg;
        src_row_next     = src_row_reg;
        plane_next       = plane_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        clr_addr_next    = clr_addr_reg;
        hwm_next         = hwm_reg;
        clr_read_next    = clr_read_reg;
        sample_next      = sample_reg;
        fs_next          = fs_reg;
        closes_next      = closes_reg;
        wprod_next       = wprod_reg;
        rprod_next       = rprod_reg;
        v_next           = v_reg;
        hprod_next       = hprod_reg;
        hrprod_next      = hrprod_reg;
        acc_next         = acc_reg;
        nprod_next       = nprod_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_sample_next    = m_sample_reg;
        m_row_end_next   = m_row_end_reg;
        m_frame_end_next = m_frame_end_reg;
        s_ready          = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_wdata        = v_reg;
        wr_addr          = addr;
        do_init          = 1'b0;
        line_done        = 1'b0;
        v_sum            = '0;
        new_span         = row_span_reg;
        last_plane       = (32'(plane_reg) + 1 >= 32'(np));
        re               = last_plane && (32'(out_col_reg) + 1 == 32'(ow));
        q = {1'b0, nprod_reg[61:32]} + (norm_recip_reg[32] ? {1'b0, acc_reg} : 31'd0);

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sample_next = s_sample;
                    fs_next     = s_frame_start;
                    state_next  = ST_INIT;
                end
            end
            ST_INIT: begin
                do_init = fs_reg;
                if (fs_reg) begin
                    clr_read_next = 1'b1;
                    state_next    = ST_CLEAR;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                mem_re      = 1'b1;
                wprod_next  = 20'(row_weight_reg * sample_reg);
                rprod_next  = 20'(rem * sample_reg);
                closes_next = (row_weight_reg == row_span_reg);
                state_next  = ST_WRITE;
            end
            ST_WRITE: begin
                v_sum     = COLACC_W'(mem_rdata + wprod_reg[COLACC_W-1:0]);
                v_next    = v_sum;
                mem_we    = 1'b1;
                mem_wdata = closes_reg ? rprod_reg[COLACC_W-1:0] : v_sum;
                if (addr > hwm_reg) begin
                    hwm_next = addr;
                end
                state_next = closes_reg ? ST_HMUL : ST_ADV;
            end
            ST_HMUL: begin
                hprod_next  = 31'(h1 * v_reg);
                hrprod_next = 31'(hrem * v_reg);
                state_next  = ST_HADD;
            end
            ST_HADD: begin
                acc_next = PIXACC_W'(pix_acc_reg[plane_reg] + hprod_reg[PIXACC_W-1:0]);
                if (span <= ow) begin
                    pix_acc_next[plane_reg]  = hrprod_reg[PIXACC_W-1:0];
                    col_span_next[plane_reg] = iw - hrem;
                    state_next = ST_NORM;
                end else begin
                    pix_acc_next[plane_reg]  = PIXACC_W'(pix_acc_reg[plane_reg]
                                               + hprod_reg[PIXACC_W-1:0]);
                    col_span_next[plane_reg] = span - h1;
                    state_next = ST_ADV;
                end
            end
            ST_NORM: begin
                nprod_next = 62'(acc_reg * norm_recip_reg[31:0]);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_sample_next    = (q > 31'd255) ? 8'd255 : q[SAMPLE_W-1:0];
                    m_row_end_next   = re;
                    m_frame_end_next = re && (32'(out_row_reg) + 1 == 32'(oh));
                    if (last_plane) begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                state_next = ST_IDLE;
                if (last_plane) begin
                    plane_next = '0;
                    if (32'(src_col_reg) + 1 >= 32'(iw)) begin
                        src_col_next = '0;
                        line_done    = 1'b1;
                        if (32'(src_row_reg) + 1 >= 32'(ih)) begin
                            do_init       = 1'b1;
                            clr_read_next = 1'b0;
                            state_next    = ST_CLEAR;
                        end else begin
                            src_row_next = src_row_reg + 1'b1;
                            if (closes_reg) begin
                                new_span     = ih - rem;
                                out_row_next = out_row_reg + 1'b1;
                            end else begin
                                new_span = (row_span_reg > oh) ? row_span_reg - oh
                                                               : DIM_W'(1);
                            end
                            row_span_next   = new_span;
                            row_weight_next = (new_span < oh) ? new_span : oh;
                        end
                    end else begin
                        src_col_next = src_col_reg + 1'b1;
                    end
                end else begin
                    plane_next = plane_reg + 1'b1;
                end
            end
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_wdata     = '0;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == hwm_reg) begin
                    clr_addr_next = '0;
                    hwm_next      = '0;
                    state_next    = clr_read_reg ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (line_done || do_init) begin
            for (int i = 0; i < MAX_PLANES; i++) begin
                col_span_next[i] = iw;
                pix_acc_next[i]  = '0;
            end
            out_col_next = '0;
        end
        if (do_init) begin
            row_span_next   = ih;
            row_weight_next = oh;
            src_col_next    = '0;
            src_row_next    = '0;
            plane_next      = '0;
            out_row_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            in_width_reg    <= DIM_W'(1);
            in_height_reg   <= DIM_W'(1);
            out_width_reg   <= DIM_W'(1);
            out_height_reg  <= DIM_W'(1);
            plane_count_reg <= PCNT_W'(1);
            norm_recip_reg  <= RECIP_RESET;
            row_weight_reg  <= DIM_W'(1);
            row_span_reg    <= DIM_W'(1);
            for (int i = 0; i < MAX_PLANES; i++) begin
                col_span_reg[i] <= DIM_W'(1);
                pix_acc_reg[i]  <= '0;
            end
            src_col_reg     <= '0;
            src_row_reg     <= '0;
            plane_reg       <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            clr_addr_reg    <= '0;
            hwm_reg         <= ADDR_W'(DEPTH - 1);
            clr_read_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_weight_reg <= row_weight_next;
            row_span_reg   <= row_span_next;
            col_span_reg   <= col_span_next;
            pix_acc_reg    <= pix_acc_next;
            src_col_reg    <= src_col_next;
            src_row_reg    <= src_row_next;
            plane_reg      <= plane_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            clr_addr_reg   <= clr_addr_next;
            hwm_reg        <= hwm_next;
            clr_read_reg   <= clr_read_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IN_WIDTH:    in_width_reg    <= cfg_wdata[DIM_W-1:0];
                    CFG_IN_HEIGHT:   in_height_reg   <= cfg_wdata[DIM_W-1:0];
                    CFG_OUT_WIDTH:   out_width_reg   <= cfg_wdata[DIM_W-1:0];
                    CFG_OUT_HEIGHT:  out_height_reg  <= cfg_wdata[DIM_W-1:0];
                    CFG_PLANE_COUNT: plane_count_reg <= cfg_wdata[PCNT_W-1:0];
                    CFG_NORM_RECIP:  norm_recip_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg      <= sample_next;
        fs_reg          <= fs_next;
        closes_reg      <= closes_next;
        wprod_reg       <= wprod_next;
        rprod_reg       <= rprod_next;
        v_reg           <= v_next;
        hprod_reg       <= hprod_next;
        hrprod_reg      <= hrprod_next;
        acc_reg         <= acc_next;
        nprod_reg       <= nprod_next;
        m_sample_reg    <= m_sample_next;
        m_row_end_reg   <= m_row_end_next;
        m_frame_end_reg <= m_frame_end_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_sample_reg;
    assign m_row_end    = m_row_end_reg;
    assign m_frame_end  = m_frame_end_reg;

endmodule
